### src/mfde_pkg.sv
// Shared types and constants for the monochrome frame-store draw engine.
// No dependencies; every other file in src imports this package.
package mfde_pkg;

   localparam int FB_WIDTH_DEF  = 128;
   localparam int FB_HEIGHT_DEF = 256;
   localparam int FB_BYTES_DEF  = (FB_WIDTH_DEF * FB_HEIGHT_DEF + 7) / 8;

   localparam int COORD_W    = 16;
   localparam int CMD_W      = 3;
   localparam int ERR_W      = COORD_W + 4;
   localparam int REQ_DATA_W = 104;
   localparam int RSP_DATA_W = 8;

   localparam logic [7:0] WHITE_BYTE = 8'hFF;
   localparam logic [7:0] TOP_BIT    = 8'h80;

   localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd0;
   localparam logic [CMD_W-1:0] CMD_SET   = 3'd1;
   localparam logic [CMD_W-1:0] CMD_GET   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_LINE  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_RECT  = 3'd4;
   localparam logic [CMD_W-1:0] CMD_FILL  = 3'd5;

   // Control from the sequencer to the line stepper.
   typedef struct packed {
      logic               load;
      logic               step;
      logic [COORD_W-1:0] x0;
      logic [COORD_W-1:0] y0;
      logic [COORD_W-1:0] x1;
      logic [COORD_W-1:0] y1;
   } line_ctl_type;

   // Current pixel of the line stepper and whether it is the end point.
   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic               last;
   } line_stat_type;

endpackage

### src/mfde_frame_mem.sv
// Byte-wide frame store: one write port and one read port, registered read data.
// Depends on mfde_pkg for its default depth.
module mfde_frame_mem #(
   parameter int DEPTH  = mfde_pkg::FB_BYTES_DEF,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [7:0]        wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [7:0]        rd_data
);
   import mfde_pkg::*;

   logic [7:0] store_ff [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/mfde_line_step.sv
// Bresenham line stepper: holds the current point and error term, one step per request.
// Depends on mfde_pkg for the control and status structs.
module mfde_line_step (
   input  logic                    clock,
   input  logic                    reset,
   input  mfde_pkg::line_ctl_type  ctl,
   output mfde_pkg::line_stat_type stat
);
   import mfde_pkg::*;

   logic [COORD_W-1:0] x_ff, x_in, y_ff, y_in;
   logic [COORD_W-1:0] x1_ff, x1_in, y1_ff, y1_in;
   logic [COORD_W-1:0] dx_ff, dx_in, dy_ff, dy_in;
   logic               xup_ff, xup_in, yup_ff, yup_in;
   logic signed [ERR_W-1:0] err_ff, err_in;
   logic signed [ERR_W-1:0] e2, pdx, pdy, ndy, sub_v, add_v;
   logic               go_x, go_y;

   always_comb begin
      x_in   = x_ff;
      y_in   = y_ff;
      x1_in  = x1_ff;
      y1_in  = y1_ff;
      dx_in  = dx_ff;
      dy_in  = dy_ff;
      xup_in = xup_ff;
      yup_in = yup_ff;
      err_in = err_ff;

      pdx   = $signed(ERR_W'(dx_ff));
      pdy   = $signed(ERR_W'(dy_ff));
      ndy   = -pdy;
      e2    = err_ff <<< 1;
      go_x  = e2 > ndy;
      go_y  = e2 < pdx;
      sub_v = go_x ? pdy : $signed(ERR_W'(0));
      add_v = go_y ? pdx : $signed(ERR_W'(0));

      if (ctl.load) begin
         x_in   = ctl.x0;
         y_in   = ctl.y0;
         x1_in  = ctl.x1;
         y1_in  = ctl.y1;
         dx_in  = (ctl.x1 > ctl.x0) ? ctl.x1 - ctl.x0 : ctl.x0 - ctl.x1;
         dy_in  = (ctl.y1 > ctl.y0) ? ctl.y1 - ctl.y0 : ctl.y0 - ctl.y1;
         xup_in = ctl.x0 < ctl.x1;
         yup_in = ctl.y0 < ctl.y1;
         err_in = $signed(ERR_W'(dx_in)) - $signed(ERR_W'(dy_in));
      end else if (ctl.step) begin
         if (go_x) begin
            x_in = xup_ff ? x_ff + COORD_W'(1) : x_ff - COORD_W'(1);
         end
         if (go_y) begin
            y_in = yup_ff ? y_ff + COORD_W'(1) : y_ff - COORD_W'(1);
         end
         err_in = err_ff - sub_v + add_v;
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      y_ff   <= y_in;
      x1_ff  <= x1_in;
      y1_ff  <= y1_in;
      dx_ff  <= dx_in;
      dy_ff  <= dy_in;
      xup_ff <= xup_in;
      yup_ff <= yup_in;
      err_ff <= err_in;
   end

   assign stat.x    = x_ff;
   assign stat.y    = y_ff;
   assign stat.last = (x_ff == x1_ff) && (y_ff == y1_ff);

   // The sequencer must never step past the end point of a line.
   a_no_step_past_end: assert property (@(posedge clock) disable iff (reset)
      ctl.step |-> !stat.last)
      else $error("line stepper advanced past its end point");

endmodule

### src/mono_framebuffer_draw_engine.sv
// Top level of the monochrome frame-store draw engine: command sequencer and pixel
// read-modify-write. Depends on mfde_pkg, mfde_frame_mem and mfde_line_step.
//
// Usage. Commands arrive on the req_ stream, one per transaction; each command returns
// exactly one rsp_ transaction carrying a status bit and a pixel bit. The picture is a
// 1-bit-per-pixel store of FB_WIDTH x FB_HEIGHT pixels packed MSB first, one byte per
// memory word, with a bit of 1 meaning white.
// Every pixel touched is a read of its byte, then, except for a get, a write of the
// modified byte in the following cycle. A clear writes one byte per cycle across the
// whole store; a set or get steps through a single point, a line through every pixel
// from start to end point, an outline through each of its edges, and a filled rectangle
// visits every screen row and every column of each covered row.
// After reset the block sweeps the whole store to white with req_tready
// low; no response is produced for that sweep. Results sit in an output register, so the
// next command is accepted while an earlier result still waits; if the receiver stalls,
// the following command finishes and then waits for the output register to drain.
// A pixel's read and write never overlap another pixel's access, so no forwarding is needed.
module mono_framebuffer_draw_engine #(
   parameter int FB_WIDTH  = mfde_pkg::FB_WIDTH_DEF,
   parameter int FB_HEIGHT = mfde_pkg::FB_HEIGHT_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // cmd[2:0], x_a[18:3], y_a[34:19], x_b[50:35], y_b[66:51], rect_w[82:67],
   // rect_h[98:83], color[99], zero padding[103:100]
   input  logic [mfde_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // status[0], pixel_value[1], zero padding[7:2]
   output logic [mfde_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import mfde_pkg::*;

   localparam int FB_PIXELS = FB_WIDTH * FB_HEIGHT;
   localparam int FB_BYTES  = (FB_PIXELS + 7) / 8;
   localparam int ADDR_W    = (FB_BYTES > 1) ? $clog2(FB_BYTES) : 1;
   localparam int PIX_W     = $clog2(FB_PIXELS);
   localparam int XW        = $clog2(FB_WIDTH);
   localparam int YW        = (FB_HEIGHT > 1) ? $clog2(FB_HEIGHT) : 1;

   typedef enum logic [6:0] {
      ST_CLEAR    = 7'b0000001,
      ST_IDLE     = 7'b0000010,
      ST_LOAD     = 7'b0000100,
      ST_PIX_RD   = 7'b0001000,
      ST_PIX_WR   = 7'b0010000,
      ST_FILL_ROW = 7'b0100000,
      ST_DONE     = 7'b1000000
   } state_type;

   // Request fields.
   logic [CMD_W-1:0]   req_cmd;
   logic [COORD_W-1:0] req_x_a, req_y_a, req_x_b, req_y_b, req_rect_w, req_rect_h;
   logic               req_color;

   assign req_cmd    = req_tdata[2:0];
   assign req_x_a    = req_tdata[18:3];
   assign req_y_a    = req_tdata[34:19];
   assign req_x_b    = req_tdata[50:35];
   assign req_y_b    = req_tdata[66:51];
   assign req_rect_w = req_tdata[82:67];
   assign req_rect_h = req_tdata[98:83];
   assign req_color  = req_tdata[99];

   state_type          state_ff, state_in;
   logic [COORD_W-1:0] xa_ff, xa_in, ya_ff, ya_in, xb_ff, xb_in, yb_ff, yb_in;
   logic [COORD_W-1:0] w_ff, w_in, h_ff, h_in;
   logic               color_ff, color_in, get_ff, get_in, rect_ff, rect_in;
   logic               fill_ff, fill_in, clr_reply_ff, clr_reply_in;
   logic [1:0]         edge_ff, edge_in;
   logic [XW-1:0]      fc_ff, fc_in;
   logic [YW-1:0]      fr_ff, fr_in;
   logic [ADDR_W-1:0]  sweep_ff, sweep_in, wr_addr_ff, wr_addr_in;
   logic [2:0]         bit_ff, bit_in;
   logic               status_ff, status_in, pix_ff, pix_in;
   logic               rsp_valid_ff, rsp_valid_in, rsp_status_ff, rsp_status_in;
   logic               rsp_pix_ff, rsp_pix_in;

   // Memory port signals.
   logic              mem_we, mem_re;
   logic [ADDR_W-1:0] mem_waddr, mem_raddr;
   logic [7:0]        mem_wdata, mem_rdata;

   line_ctl_type  lctl;
   line_stat_type lstat;

   // Pixel under the cursor.
   logic [COORD_W-1:0] px, py;
   logic               pix_on, row_on, req_on, adv;
   logic [PIX_W-1:0]   pix_n;
   logic [ADDR_W-1:0]  pix_addr;
   logic [7:0]         mask;

   mfde_frame_mem #(
      .DEPTH  (FB_BYTES),
      .ADDR_W (ADDR_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   mfde_line_step u_line (
      .clock (clock),
      .reset (reset),
      .ctl   (lctl),
      .stat  (lstat)
   );

   // Cursor selection and byte address of the current pixel.
   always_comb begin
      if (fill_ff) begin
         px     = COORD_W'(fc_ff);
         py     = COORD_W'(fr_ff);
         pix_on = (px - xa_ff) < w_ff;
      end else begin
         px     = lstat.x;
         py     = lstat.y;
         pix_on = (px < COORD_W'(FB_WIDTH)) && (py < COORD_W'(FB_HEIGHT));
      end
      pix_n    = PIX_W'(PIX_W'(py[YW-1:0]) * PIX_W'(FB_WIDTH)) + PIX_W'(px[XW-1:0]);
      pix_addr = ADDR_W'(pix_n >> 3);
      row_on   = (COORD_W'(fr_ff) - ya_ff) < h_ff;
      mask     = TOP_BIT >> bit_ff;
      req_on   = (req_x_a < COORD_W'(FB_WIDTH)) && (req_y_a < COORD_W'(FB_HEIGHT));
   end

   assign req_tready = (state_ff == ST_IDLE);

   // Sequencer.
   always_comb begin
      state_in      = state_ff;
      xa_in         = xa_ff;
      ya_in         = ya_ff;
      xb_in         = xb_ff;
      yb_in         = yb_ff;
      w_in          = w_ff;
      h_in          = h_ff;
      color_in      = color_ff;
      get_in        = get_ff;
      rect_in       = rect_ff;
      fill_in       = fill_ff;
      clr_reply_in  = clr_reply_ff;
      edge_in       = edge_ff;
      fc_in         = fc_ff;
      fr_in         = fr_ff;
      sweep_in      = sweep_ff;
      wr_addr_in    = wr_addr_ff;
      bit_in        = bit_ff;
      status_in     = status_ff;
      pix_in        = pix_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_pix_in    = rsp_pix_ff;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      mem_waddr     = wr_addr_ff;
      mem_raddr     = pix_addr;
      mem_wdata     = color_ff ? (mem_rdata | mask) : (mem_rdata & ~mask);
      adv           = 1'b0;

      lctl.load = 1'b0;
      lctl.step = 1'b0;
      if (!rect_ff) begin
         lctl.x0 = xa_ff;
         lctl.y0 = ya_ff;
         lctl.x1 = xb_ff;
         lctl.y1 = yb_ff;
      end else begin
         unique case (edge_ff)
            2'd0: begin
               lctl.x0 = xa_ff; lctl.y0 = ya_ff; lctl.x1 = xb_ff; lctl.y1 = ya_ff;
            end
            2'd1: begin
               lctl.x0 = xa_ff; lctl.y0 = yb_ff; lctl.x1 = xb_ff; lctl.y1 = yb_ff;
            end
            2'd2: begin
               lctl.x0 = xa_ff; lctl.y0 = ya_ff; lctl.x1 = xa_ff; lctl.y1 = yb_ff;
            end
            default: begin
               lctl.x0 = xb_ff; lctl.y0 = ya_ff; lctl.x1 = xb_ff; lctl.y1 = yb_ff;
            end
         endcase
      end

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = sweep_ff;
            mem_wdata = WHITE_BYTE;
            if (sweep_ff == ADDR_W'(FB_BYTES - 1)) begin
               sweep_in = '0;
               state_in = clr_reply_ff ? ST_DONE : ST_IDLE;
            end else begin
               sweep_in = sweep_ff + ADDR_W'(1);
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               xa_in     = req_x_a;
               ya_in     = req_y_a;
               w_in      = req_rect_w;
               h_in      = req_rect_h;
               color_in  = req_color;
               get_in    = (req_cmd == CMD_GET);
               rect_in   = (req_cmd == CMD_RECT);
               fill_in   = (req_cmd == CMD_FILL);
               status_in = ((req_cmd == CMD_SET) || (req_cmd == CMD_GET)) && !req_on;
               pix_in    = 1'b0;
               edge_in   = 2'd0;
               fc_in     = '0;
               fr_in     = '0;
               // Set and get draw a single-point line; an outline keeps its
               // far corner, wrapped to 16 bits, in the end-point registers.
               if (req_cmd == CMD_RECT) begin
                  xb_in = req_x_a + req_rect_w - COORD_W'(1);
                  yb_in = req_y_a + req_rect_h - COORD_W'(1);
               end else if (req_cmd == CMD_LINE) begin
                  xb_in = req_x_b;
                  yb_in = req_y_b;
               end else begin
                  xb_in = req_x_a;
                  yb_in = req_y_a;
               end
               unique case (req_cmd)
                  CMD_CLEAR: begin
                     clr_reply_in = 1'b1;
                     state_in     = ST_CLEAR;
                  end
                  CMD_SET, CMD_GET, CMD_LINE, CMD_RECT: state_in = ST_LOAD;
                  CMD_FILL: state_in = ST_FILL_ROW;
                  default:  state_in = ST_DONE;
               endcase
            end
         end
         ST_LOAD: begin
            lctl.load = 1'b1;
            state_in  = ST_PIX_RD;
         end
         ST_PIX_RD: begin
            if (pix_on) begin
               mem_re     = 1'b1;
               wr_addr_in = pix_addr;
               bit_in     = pix_n[2:0];
               state_in   = ST_PIX_WR;
            end else begin
               adv = 1'b1;
            end
         end
         ST_PIX_WR: begin
            if (get_ff) begin
               pix_in = |(mem_rdata & mask);
            end else begin
               mem_we = 1'b1;
            end
            adv = 1'b1;
         end
         ST_FILL_ROW: begin
            if (row_on) begin
               fc_in    = '0;
               state_in = ST_PIX_RD;
            end else if (fr_ff == YW'(FB_HEIGHT - 1)) begin
               state_in = ST_DONE;
            end else begin
               fr_in = fr_ff + YW'(1);
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_pix_in    = pix_ff;
               clr_reply_in  = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // Move to the next pixel of the running command.
      if (adv) begin
         if (fill_ff) begin
            if (fc_ff == XW'(FB_WIDTH - 1)) begin
               fc_in = '0;
               if (fr_ff == YW'(FB_HEIGHT - 1)) begin
                  state_in = ST_DONE;
               end else begin
                  fr_in    = fr_ff + YW'(1);
                  state_in = ST_FILL_ROW;
               end
            end else begin
               fc_in    = fc_ff + XW'(1);
               state_in = ST_PIX_RD;
            end
         end else if (lstat.last) begin
            if (rect_ff && (edge_ff != 2'd3)) begin
               edge_in  = edge_ff + 2'd1;
               state_in = ST_LOAD;
            end else begin
               state_in = ST_DONE;
            end
         end else begin
            lctl.step = 1'b1;
            state_in  = ST_PIX_RD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         sweep_ff     <= '0;
         clr_reply_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         clr_reply_ff <= clr_reply_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      xa_ff         <= xa_in;
      ya_ff         <= ya_in;
      xb_ff         <= xb_in;
      yb_ff         <= yb_in;
      w_ff          <= w_in;
      h_ff          <= h_in;
      color_ff      <= color_in;
      get_ff        <= get_in;
      rect_ff       <= rect_in;
      fill_ff       <= fill_in;
      edge_ff       <= edge_in;
      fc_ff         <= fc_in;
      fr_ff         <= fr_in;
      wr_addr_ff    <= wr_addr_in;
      bit_ff        <= bit_in;
      status_ff     <= status_in;
      pix_ff        <= pix_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pix_ff    <= rsp_pix_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - 2){1'b0}}, rsp_pix_ff, rsp_status_ff};

   // Reads and writes of the store belong to different phases of a pixel.
   a_no_rw_same_cycle: assert property (@(posedge clock) disable iff (reset)
      !(mem_we && mem_re))
      else $error("frame store read and written in the same cycle");

   // A pixel value is only reported by a get whose coordinate was on screen.
   a_pix_implies_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_pix_ff && rsp_status_ff))
      else $error("pixel value reported together with an out-of-range status");

   // The clearing sweep after reset holds off new commands.
   a_sweep_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !req_tready)
      else $error("command accepted before the initial clear completed");

endmodule
